FILE: sv/cdp_trace_stacker_core_assert.svh
// Assertion macros for the trace stacker core
`ifndef CDP_TRACE_STACKER_CORE_ASSERT_SVH
`define CDP_TRACE_STACKER_CORE_ASSERT_SVH
// same-cycle implication
`define CDP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CDP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: sv/cdp_ts_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the trace stacker
package cdp_ts_pkg;
	localparam int MAX_SAMPLES = 1024;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int NS_W        = ADDR_W + 1;
	localparam int MAX_FOLD    = 64;
	localparam int FOLD_W      = $clog2(MAX_FOLD) + 1;
	localparam int SAMPLE_BITS = 24;
	localparam int SUM_W       = 31;
	localparam int CFG_W       = 16;

	localparam logic [1:0] REG_NUM_SAMPLES = 2'd0;
	localparam logic [1:0] REG_TIME_ORIGIN = 2'd1;
	localparam logic [1:0] REG_INTERVAL    = 2'd2;
	localparam logic [1:0] REG_NORM_MODE   = 2'd3;

	localparam logic [1:0] NORM_RAW   = 2'd0;
	localparam logic [1:0] NORM_COUNT = 2'd1;
	localparam logic [1:0] NORM_SQRT  = 2'd2;
endpackage

FILE: sv/cdp_ts_if.sv
`timescale 1ns / 1ps
// Sample request and stacked result channel interfaces
interface cdp_ts_sample_if;
	logic                                        valid;
	logic                                        ready;
	logic                                        kind;
	logic [30:0]                                 gather_number;
	logic signed [15:0]                          mute_top_time;
	logic signed [15:0]                          mute_bottom_time;
	logic signed [cdp_ts_pkg::SAMPLE_BITS-1:0]   sample_value;
	modport source (output valid, kind, gather_number, mute_top_time, mute_bottom_time,
		sample_value, input ready);
	modport sink (input valid, kind, gather_number, mute_top_time, mute_bottom_time,
		sample_value, output ready);
endinterface

interface cdp_ts_stack_if;
	logic                                        valid;
	logic                                        ready;
	logic [cdp_ts_pkg::ADDR_W-1:0]               sample_position;
	logic signed [cdp_ts_pkg::SAMPLE_BITS-1:0]   stacked_value;
	logic [cdp_ts_pkg::FOLD_W-1:0]               gather_fold;
	logic signed [15:0]                          gather_mute_top;
	logic signed [15:0]                          gather_mute_bottom;
	logic [31:0]                                 output_trace_number;
	logic                                        fold_overflow;
	logic                                        last_sample;
	modport source (output valid, sample_position, stacked_value, gather_fold,
		gather_mute_top, gather_mute_bottom, output_trace_number, fold_overflow,
		last_sample, input ready);
	modport sink (input valid, sample_position, stacked_value, gather_fold,
		gather_mute_top, gather_mute_bottom, output_trace_number, fold_overflow,
		last_sample, output ready);
endinterface

FILE: sv/cdp_trace_stacker_core.sv
`timescale 1ns / 1ps
// CDP stacker core: sum/count memory, shared iterative divider and square root
//
// channel   | dir | handshake    | payload
// samples   | in  | valid/ready  | kind, gather, mute times, sample value
// stacked   | out | valid/ready  | position, stacked value, gather headers
// cfg       | in  | write enable | register index, 16-bit data
//
// One request at a time: at a trace's first sample, two mute index divides and a decision
// step come first; a raw result is emitted directly, count normalization takes a divide,
// and square-root normalization a squaring, a divide and a square root.
// Sum and count share one 1024-entry memory, read through a register and written back later.
// After reset a clearing pass over all 1024 entries runs before the first request is taken.
// A stalled result holds in the output register; the next request is still taken.
`include "cdp_trace_stacker_core_assert.svh"
module cdp_trace_stacker_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [1:0]                    cfg_index,
	input  logic [cdp_ts_pkg::CFG_W-1:0]  cfg_data,
	cdp_ts_sample_if.sink                 samples,
	cdp_ts_stack_if.source                stacked
);
	localparam int AW = cdp_ts_pkg::ADDR_W;
	localparam int NW = cdp_ts_pkg::NS_W;
	localparam int FW = cdp_ts_pkg::FOLD_W;
	localparam int SB = cdp_ts_pkg::SAMPLE_BITS;
	localparam int SW = cdp_ts_pkg::SUM_W;
	localparam int MW = SW + FW;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_TPREP, ST_TDIV, ST_BPREP, ST_BDIV, ST_DECIDE,
		ST_READ, ST_RDATA, ST_MUL, ST_QLOAD, ST_QDIV, ST_NDIV, ST_SQRT, ST_EMIT, ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		TM_IDLE, TM_LOAD, TM_ADD, TM_SKIP, TM_REPLACE, TM_CLEAR
	} tmode_t;

	state_t                state_q;
	tmode_t                tmode_q;
	logic [AW-1:0]         clr_cnt_q;
	logic [NW-1:0]         ns_q;
	logic signed [15:0]    origin_q;
	logic [15:0]           interval_q;
	logic [1:0]            norm_q;
	logic                  kind_q;
	logic [30:0]           gnum_q;
	logic signed [SB-1:0]  val_q;
	logic signed [15:0]    ttop_q, tbot_q;
	logic                  gather_started_q, draining_q, ovf_q;
	logic [30:0]           cur_gather_q;
	logic [FW-1:0]         trace_count_q;
	logic signed [15:0]    min_top_q, max_bot_q;
	logic [AW-1:0]         cnt_q;
	logic [31:0]           traces_out_q;
	logic [NW-1:0]         win_lo_q, win_hi_q;
	logic signed [27:0]    it_q;

	logic [63:0]           div_n_q;
	logic [16:0]           div_r_q, div_d_q;
	logic [6:0]            step_q;
	logic                  dneg_q;

	logic [30:0]           a_q;
	logic                  sneg_q;
	logic [FW-1:0]         c_q;
	logic [61:0]           sq_q;
	logic [63:0]           sq_x_q;
	logic [34:0]           sq_rem_q;
	logic [31:0]           sq_res_q;
	logic signed [SB-1:0]  res_q;

	logic                  ovalid_q;
	logic [AW-1:0]         o_pos_q;
	logic signed [SB-1:0]  o_val_q;
	logic [FW-1:0]         o_fold_q;
	logic signed [15:0]    o_top_q, o_bot_q;
	logic [31:0]           o_num_q;
	logic                  o_ovf_q, o_last_q;

	logic [MW-1:0]         mem [cdp_ts_pkg::MAX_SAMPLES];
	logic [MW-1:0]         mem_rd_q;
	logic [MW-1:0]         mem_wdata;
	logic [AW-1:0]         mem_addr;
	logic                  mem_we;

	function automatic logic signed [SB-1:0] sat(input logic signed [33:0] v);
		logic signed [33:0] hi, lo;
		hi = 34'sd2 ** (SB - 1) - 34'sd1;
		lo = -(34'sd2 ** (SB - 1));
		if (v > hi) return SB'(hi);
		if (v < lo) return SB'(lo);
		return SB'(v);
	endfunction

	logic [NW-1:0]         n1;
	logic                  last_c, live_c, drain_c, out_free;
	logic signed [16:0]    tdiff;
	logic signed [26:0]    tprod;
	logic [25:0]           tmag;
	logic [16:0]           ivl;
	logic [17:0]           rem_sh;
	logic                  div_ge;
	logic [34:0]           sq_sh, sq_trial;
	logic                  sq_ge;
	logic signed [27:0]    idx_c, n1_s;
	logic signed [SW-1:0]  rd_sum;
	logic [FW-1:0]         rd_cnt;
	logic [30:0]           rd_mag;
	logic [32:0]           sq_m;
	logic [31:0]           m1_m;

	always_comb begin
		if (ns_q == '0) n1 = NW'(1);
		else if (ns_q > NW'(cdp_ts_pkg::MAX_SAMPLES)) n1 = NW'(cdp_ts_pkg::MAX_SAMPLES);
		else n1 = ns_q;
	end

	assign last_c   = ({1'b0, cnt_q} + NW'(1)) >= n1;
	assign live_c   = (win_lo_q <= {1'b0, cnt_q}) && ({1'b0, cnt_q} < win_hi_q);
	assign drain_c  = (tmode_q == TM_REPLACE) || (tmode_q == TM_CLEAR);
	assign out_free = !ovalid_q || stacked.ready;

	assign tdiff = (state_q == ST_TPREP) ? ($signed({ttop_q[15], ttop_q}) - origin_q)
		: ($signed({tbot_q[15], tbot_q}) - origin_q);
	assign tprod = 27'(tdiff) * 27'sd1000;
	assign tmag  = tprod[26] ? 26'(-tprod) : tprod[25:0];
	assign ivl   = (interval_q == '0) ? 17'd1 : {1'b0, interval_q};

	assign rem_sh = {div_r_q, div_n_q[63]};
	assign div_ge = rem_sh >= {1'b0, div_d_q};

	assign sq_sh    = {sq_rem_q[32:0], sq_x_q[63:62]};
	assign sq_trial = {1'b0, sq_res_q, 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;

	assign idx_c = dneg_q ? -$signed({1'b0, div_n_q[26:0]}) : $signed({1'b0, div_n_q[26:0]});
	assign n1_s  = $signed({17'd0, n1});

	assign rd_sum = $signed(mem_rd_q[MW-1:FW]);
	assign rd_cnt = mem_rd_q[FW-1:0];
	assign rd_mag = rd_sum[SW-1] ? 31'(-rd_sum) : 31'(rd_sum);
	assign sq_m   = ({1'b0, sq_res_q} + 33'd1) >> 1;
	assign m1_m   = div_n_q[31:0];

	always_comb begin
		case (tmode_q)
			TM_LOAD, TM_REPLACE: mem_wdata = live_c ? {SW'(val_q), FW'(1)} : '0;
			TM_CLEAR:            mem_wdata = '0;
			TM_ADD:              mem_wdata = live_c ? {rd_sum + SW'(val_q), rd_cnt + FW'(1)}
				: mem_rd_q;
			default:             mem_wdata = mem_rd_q;
		endcase
	end

	assign mem_addr = (state_q == ST_CLEAR) ? clr_cnt_q : cnt_q;
	assign mem_we   = (state_q == ST_CLEAR) || (state_q == ST_RDATA && !drain_c)
		|| (state_q == ST_EMIT && out_free);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= (state_q == ST_CLEAR) ? '0 : mem_wdata;
		end
		mem_rd_q <= mem[mem_addr];
	end

	assign samples.ready = (state_q == ST_IDLE);

	assign stacked.valid               = ovalid_q;
	assign stacked.sample_position     = o_pos_q;
	assign stacked.stacked_value       = o_val_q;
	assign stacked.gather_fold         = o_fold_q;
	assign stacked.gather_mute_top     = o_top_q;
	assign stacked.gather_mute_bottom  = o_bot_q;
	assign stacked.output_trace_number = o_num_q;
	assign stacked.fold_overflow       = o_ovf_q;
	assign stacked.last_sample         = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_CLEAR;
			tmode_q          <= TM_IDLE;
			clr_cnt_q        <= '0;
			ns_q             <= NW'(cdp_ts_pkg::MAX_SAMPLES);
			origin_q         <= '0;
			interval_q       <= 16'd4000;
			norm_q           <= cdp_ts_pkg::NORM_COUNT;
			gather_started_q <= 1'b0;
			draining_q       <= 1'b0;
			ovf_q            <= 1'b0;
			cur_gather_q     <= '0;
			trace_count_q    <= '0;
			min_top_q        <= '0;
			max_bot_q        <= '0;
			cnt_q            <= '0;
			traces_out_q     <= '0;
			win_lo_q         <= '0;
			win_hi_q         <= '0;
			ttop_q           <= '0;
			tbot_q           <= '0;
			ovalid_q         <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					cdp_ts_pkg::REG_NUM_SAMPLES: ns_q       <= cfg_data[NW-1:0];
					cdp_ts_pkg::REG_TIME_ORIGIN: origin_q   <= $signed(cfg_data);
					cdp_ts_pkg::REG_INTERVAL:    interval_q <= cfg_data;
					cdp_ts_pkg::REG_NORM_MODE:   norm_q     <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (stacked.ready && state_q != ST_EMIT) ovalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(cdp_ts_pkg::MAX_SAMPLES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (samples.valid) begin
						val_q <= samples.sample_value;
						if (cnt_q == '0) begin
							kind_q  <= samples.kind;
							gnum_q  <= samples.gather_number;
							ttop_q  <= samples.mute_top_time;
							tbot_q  <= samples.mute_bottom_time;
							state_q <= ST_TPREP;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_TPREP, ST_BPREP: begin
					if (state_q == ST_BPREP) it_q <= idx_c;
					div_n_q <= {38'd0, tmag};
					div_r_q <= '0;
					div_d_q <= ivl;
					dneg_q  <= tprod[26];
					step_q  <= 7'd64;
					state_q <= (state_q == ST_TPREP) ? ST_TDIV : ST_BDIV;
				end
				ST_TDIV, ST_BDIV, ST_QDIV, ST_NDIV: begin
					div_r_q <= div_ge ? 17'(rem_sh - {1'b0, div_d_q}) : rem_sh[16:0];
					div_n_q <= {div_n_q[62:0], div_ge};
					step_q  <= step_q - 7'd1;
					if (step_q == 7'd1) begin
						case (state_q)
							ST_TDIV: state_q <= ST_BPREP;
							ST_BDIV: state_q <= ST_DECIDE;
							ST_QDIV: begin
								sq_x_q   <= {div_n_q[62:0], div_ge};
								sq_rem_q <= '0;
								sq_res_q <= '0;
								step_q   <= 7'd32;
								state_q  <= ST_SQRT;
							end
							default: begin
								res_q   <= sat(sneg_q ? -$signed({2'b0, m1_m[30:0], div_ge})
									: $signed({2'b0, m1_m[30:0], div_ge}));
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_DECIDE: begin
					if (it_q < 0) win_lo_q <= '0;
					else if (it_q > n1_s) win_lo_q <= n1;
					else win_lo_q <= it_q[NW-1:0];
					if (idx_c <= 28'sd1 || idx_c > n1_s) win_hi_q <= n1;
					else win_hi_q <= idx_c[NW-1:0];
					if (kind_q) begin
						tmode_q <= gather_started_q ? TM_CLEAR : TM_IDLE;
						if (gather_started_q) begin
							draining_q   <= 1'b1;
							traces_out_q <= traces_out_q + 32'd1;
						end
					end else if (!gather_started_q) begin
						tmode_q          <= TM_LOAD;
						gather_started_q <= 1'b1;
						cur_gather_q     <= gnum_q;
						trace_count_q    <= FW'(1);
						min_top_q        <= ttop_q;
						max_bot_q        <= tbot_q;
						ovf_q            <= 1'b0;
					end else if (gnum_q == cur_gather_q) begin
						if (trace_count_q >= FW'(cdp_ts_pkg::MAX_FOLD)) begin
							tmode_q <= TM_SKIP;
							ovf_q   <= 1'b1;
						end else begin
							tmode_q       <= TM_ADD;
							trace_count_q <= trace_count_q + FW'(1);
							if (ttop_q < min_top_q) min_top_q <= ttop_q;
							if (tbot_q > max_bot_q) max_bot_q <= tbot_q;
						end
					end else begin
						tmode_q      <= TM_REPLACE;
						cur_gather_q <= gnum_q;
						draining_q   <= 1'b1;
						traces_out_q <= traces_out_q + 32'd1;
					end
					state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_RDATA;
				ST_RDATA: begin
					a_q    <= rd_mag;
					sneg_q <= rd_sum[SW-1];
					c_q    <= rd_cnt;
					if (!drain_c) begin
						state_q <= ST_DONE;
					end else if (norm_q == cdp_ts_pkg::NORM_RAW || rd_cnt <= FW'(1)) begin
						res_q   <= sat(34'(rd_sum));
						state_q <= ST_EMIT;
					end else if (norm_q == cdp_ts_pkg::NORM_SQRT) begin
						state_q <= ST_MUL;
					end else begin
						div_n_q <= {32'd0, 32'({rd_mag, 1'b0}) + 32'(rd_cnt)};
						div_r_q <= '0;
						div_d_q <= 17'({rd_cnt, 1'b0});
						step_q  <= 7'd64;
						state_q <= ST_NDIV;
					end
				end
				ST_MUL: begin
					sq_q    <= 62'(a_q * a_q);
					state_q <= ST_QLOAD;
				end
				ST_QLOAD: begin
					div_n_q <= {sq_q, 2'b00};
					div_r_q <= '0;
					div_d_q <= 17'(c_q);
					step_q  <= 7'd64;
					state_q <= ST_QDIV;
				end
				ST_SQRT: begin
					sq_rem_q <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
					sq_res_q <= {sq_res_q[30:0], sq_ge};
					sq_x_q   <= {sq_x_q[61:0], 2'b00};
					step_q   <= step_q - 7'd1;
					if (step_q == 7'd1) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						o_pos_q  <= cnt_q;
						o_val_q  <= (norm_q == cdp_ts_pkg::NORM_SQRT && c_q > FW'(1))
							? sat(sneg_q ? -$signed({1'b0, sq_m}) : $signed({1'b0, sq_m}))
							: res_q;
						o_fold_q <= trace_count_q;
						o_top_q  <= min_top_q;
						o_bot_q  <= max_bot_q;
						o_num_q  <= traces_out_q;
						o_ovf_q  <= ovf_q;
						o_last_q <= last_c;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (last_c) begin
						cnt_q <= '0;
						if (tmode_q == TM_REPLACE) begin
							trace_count_q <= FW'(1);
							min_top_q     <= ttop_q;
							max_bot_q     <= tbot_q;
							ovf_q         <= 1'b0;
							draining_q    <= 1'b0;
						end else if (tmode_q == TM_CLEAR) begin
							gather_started_q <= 1'b0;
							trace_count_q    <= '0;
							min_top_q        <= '0;
							max_bot_q        <= '0;
							ovf_q            <= 1'b0;
							draining_q       <= 1'b0;
						end
						tmode_q <= TM_IDLE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CDP_ASSERT_IMPL(a_fold_needs_gather, !gather_started_q, trace_count_q == '0, "fold count without open gather")
	`CDP_ASSERT_IMPL(a_fold_limit, 1'b1, trace_count_q <= FW'(cdp_ts_pkg::MAX_FOLD), "fold count beyond limit")
	`CDP_ASSERT_IMPL(a_drain_in_gather, draining_q, gather_started_q, "draining with no gather open")
	`CDP_ASSERT_NEXT(a_one_request, samples.valid && samples.ready, !samples.ready, "second request taken while busy")
endmodule
